@@ hw/rtl/c3cf_pkg.sv @@
// Shared types and constants for the 3x3 convolution filter.
package c3cf_pkg;
  localparam int MaxWidth = 1024;
  localparam int AddrW = $clog2(MaxWidth);
  localparam int DivSteps = 19;  // dividend magnitude bits, one quotient bit per cell

  typedef enum logic [2:0] {
    REG_COEFF_TOP = 3'd0,
    REG_COEFF_MID = 3'd1,
    REG_COEFF_BOT = 3'd2,
    REG_DIVISOR   = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5
  } reg_idx_t;

  // side info carried along the divider chain
  typedef struct packed {
    logic       neg;
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
  } tag_t;

  // one divider cell's state
  typedef struct packed {
    logic                valid;
    tag_t                tag;
    logic [7:0]          dvs;
    logic [DivSteps-1:0] rem_num;  // numerator bits shifted out toward the remainder
    logic [8:0]          rem;
    logic [DivSteps-1:0] quo;
  } dcell_t;
endpackage

@@ hw/rtl/c3cf_div_cell.sv @@
// One restoring-division step cell: produces one quotient bit and hands on.
module c3cf_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  c3cf_pkg::dcell_t din,
  output c3cf_pkg::dcell_t dout
);
  import c3cf_pkg::*;
  logic [9:0] trial;
  logic [9:0] shifted;
  dcell_t nxt;

  always_comb begin
    nxt = din;
    shifted = {din.rem, din.rem_num[DivSteps-1]};
    trial = shifted - {2'b00, din.dvs};
    nxt.rem_num = {din.rem_num[DivSteps-2:0], 1'b0};
    if (!trial[9]) begin
      nxt.rem = trial[8:0];
      nxt.quo = {din.quo[DivSteps-2:0], 1'b1};
    end else begin
      nxt.rem = shifted[8:0];
      nxt.quo = {din.quo[DivSteps-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.tag <= nxt.tag;
      dout.dvs <= nxt.dvs;
      dout.rem_num <= nxt.rem_num;
      dout.rem <= nxt.rem;
      dout.quo <= nxt.quo;
    end
  end
endmodule

@@ hw/rtl/conv3x3_clamp_filter.sv @@
// Top level of the streaming 3x3 convolution filter with clamping.
// Pixels enter in raster order, one item a cycle when the output side keeps
// up. Two line memories hold the previous two rows; a 3x3 window of
// registers holds the band. Each interior pixel's nine products are formed
// in one stage, summed in a second, then the magnitude goes through a chain
// of 19 restoring-division cells, one quotient bit per cell, before sign,
// clamp and the output register. Throughput is one item per cycle while
// the output is not stalled. The whole pipeline advances only when the
// output register is free or being emptied, so back-pressure stalls the
// input. Border pixels produce no item. The line memories are not cleared;
// rows are valid once written from row 0 of a frame.
module conv3x3_clamp_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  input  logic        first_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  filtered,
  output logic [9:0]  center_column,
  output logic [9:0]  center_row,
  output logic        last_of_frame
);
  import c3cf_pkg::*;

  // configuration registers
  logic [23:0] coef [3];
  logic [7:0]  divisor;
  logic [10:0] frame_width;
  logic [10:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= 24'd0;
      coef[1] <= 24'd256;
      coef[2] <= 24'd0;
      divisor <= 8'd1;
      frame_width <= 11'd1024;
      frame_height <= 11'd1024;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COEFF_TOP: coef[0] <= cfg_data;
        REG_COEFF_MID: coef[1] <= cfg_data;
        REG_COEFF_BOT: coef[2] <= cfg_data;
        REG_DIVISOR:   divisor <= cfg_data[7:0];
        REG_WIDTH:     frame_width <= cfg_data[10:0];
        REG_HEIGHT:    frame_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [10:0] eff_w, eff_h;
  logic [7:0]  eff_div;
  assign eff_w = (frame_width < 11'd3) ? 11'd3 :
                 (frame_width > 11'(MaxWidth)) ? 11'(MaxWidth) : frame_width;
  assign eff_h = (frame_height < 11'd3) ? 11'd3 : frame_height;
  assign eff_div = (divisor == 8'd0) ? 8'd1 : divisor;

  // pipeline advances when the output register can take a new value
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  logic acc;
  assign acc = in_valid && in_ready;

  // position counters
  logic [10:0] column_count, row_count;
  logic [10:0] c0, r0, c_cur, r_cur, c_inc, r_inc;
  always_comb begin
    c0 = first_of_frame ? 11'd0 : column_count;
    r0 = first_of_frame ? 11'd0 : row_count;
    c_cur = (c0 >= eff_w) ? 11'd0 : c0;
    r_cur = (r0 >= eff_h) ? 11'd0 : r0;
    c_inc = c_cur + 11'd1;
    r_inc = r_cur;
    if (c_inc >= eff_w) begin
      c_inc = 11'd0;
      r_inc = r_cur + 11'd1;
      if (r_inc >= eff_h) r_inc = 11'd0;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 11'd0;
      row_count <= 11'd0;
    end else if (acc) begin
      column_count <= c_inc;
      row_count <= r_inc;
    end
  end

  // stage 1: line memory read; hold pixel and position
  logic [7:0] mem_up [MaxWidth];
  logic [7:0] mem_lo [MaxWidth];
  logic [AddrW-1:0] addr;
  assign addr = c_cur[AddrW-1:0];
  logic [7:0] up_q, lo_q, px1;
  logic       v1, emit1, last1;
  logic [9:0] ccol1, crow1;
  logic [AddrW-1:0] addr1;
  always_ff @(posedge clk) begin
    if (acc) begin
      if (v1 && addr1 == addr) begin
        // the previous item writes this address at the same edge: forward it
        up_q <= lo_q;
        lo_q <= px1;
      end else begin
        up_q <= mem_up[addr];
        lo_q <= mem_lo[addr];
      end
    end
  end
  // write-back of the rotated column from the stage-1 registers (same address)
  always_ff @(posedge clk) begin
    if (v1 && adv) begin
      mem_up[addr1] <= lo_q;
      mem_lo[addr1] <= px1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= acc;
    end
    if (acc) begin
      px1 <= pixel;
      addr1 <= addr;
      emit1 <= (c_cur >= 11'd2) && (r_cur >= 11'd2);
      ccol1 <= 10'(c_cur - 11'd1);
      crow1 <= 10'(r_cur - 11'd1);
      last1 <= (c_cur == eff_w - 11'd1) && (r_cur == eff_h - 11'd1);
    end
  end
  // A frame restart right after a column-0 item repeats the address of the
  // item still in stage 1; the read above takes the pending write-back instead.

  // window: win[x][y], x = 0 oldest column
  logic [7:0] win [3][3];
  logic [7:0] col1 [3];
  assign col1[0] = up_q;
  assign col1[1] = lo_q;
  assign col1[2] = px1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int x = 0; x < 2; x++)
        for (int y = 0; y < 3; y++) win[x][y] <= 8'd0;
    end else if (v1 && adv) begin
      for (int y = 0; y < 3; y++) begin
        win[0][y] <= win[1][y];
        win[1][y] <= col1[y];
      end
    end
  end
  always_comb begin
    for (int y = 0; y < 3; y++) win[2][y] = col1[y];
  end

  // stage 2: nine products
  logic signed [16:0] prod [3][3];
  logic v2;
  tag_t tag2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && emit1;
    end
    if (adv) begin
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++)
          prod[y][x] <= $signed(coef[y][8*x +: 8]) * $signed({1'b0, win[x][y]});
      tag2.neg <= 1'b0;
      tag2.col <= ccol1;
      tag2.row <= crow1;
      tag2.last <= last1;
    end
  end

  // stage 3: sum and magnitude
  logic signed [20:0] sum;
  always_comb begin
    sum = '0;
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) sum = sum + 21'(prod[y][x]);
  end
  dcell_t chain [DivSteps+1];
  logic [20:0] mag;
  assign mag = sum[20] ? 21'(-sum) : sum;
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid <= v2;
    end
    if (adv) begin
      chain[0].tag <= '{neg: sum[20], col: tag2.col, row: tag2.row, last: tag2.last};
      chain[0].dvs <= eff_div;
      chain[0].rem_num <= mag[DivSteps-1:0];
      chain[0].rem <= '0;
      chain[0].quo <= '0;
    end
  end

  // division chain
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    c3cf_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  // sign, clamp, output register
  dcell_t fin;
  assign fin = chain[DivSteps];
  logic [7:0] clamped;
  assign clamped = (fin.tag.neg || fin.quo == '0) ? 8'd0 :
                   (fin.quo > DivSteps'(255)) ? 8'd255 : fin.quo[7:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin.valid;
    end
    if (adv) begin
      filtered <= clamped;
      center_column <= fin.tag.col;
      center_row <= fin.tag.row;
      last_of_frame <= fin.tag.last;
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("output item changed while stalled");
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output register");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    acc |=> column_count < eff_w)
    else $error("column count out of range");
`endif
endmodule
